// File: sv/bce_pkg.sv
// Shared types and constants of the battery charge estimator.
// Used by bce_div, bce_ctrl, bce_datapath and battery_charge_estimator.

package bce_pkg;

  localparam int unsigned PERCENT_STEPS_DEF = 100;

  localparam int unsigned MV_W       = 16;
  localparam int unsigned PCT_W      = 8;
  localparam int unsigned IDX_W      = 7;
  localparam int unsigned LIMIT_W    = 7;
  localparam int unsigned OFS_W      = 13;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned ALARM_W    = 2;

  // smoothing: one new sample plus four history values
  localparam int unsigned HIST_DEPTH = 4;
  localparam int unsigned SMOOTH_DIV = 5;
  localparam int unsigned SUM_W      = MV_W + 3;
  localparam int unsigned DVSR_W     = 8;

  // divide by five as a multiply by ceil(2^21 / 5) and a right shift by 21;
  // exact for every sum below 2^19
  localparam int unsigned      SMOOTH_SHIFT = 21;
  localparam logic [SUM_W-1:0] SMOOTH_RECIP = 19'd419431;

  typedef enum logic {
    OP_SAMPLE   = 1'b0,
    OP_TABLE_WR = 1'b1
  } op_e;

  typedef enum logic [ALARM_W-1:0] {
    ALARM_NONE        = 2'd0,
    ALARM_LOW_CHARGE  = 2'd1,
    ALARM_LOW_VOLTAGE = 2'd2
  } alarm_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_CHARGE_LIMIT  = 3'd0,
    REG_LOW_VOLTAGE_LIMIT = 3'd1,
    REG_REMAP_ENABLE      = 3'd2,
    REG_REMAP_FROM_MAX    = 3'd3,
    REG_REMAP_FROM_MIN    = 3'd4,
    REG_REMAP_TO_MAX      = 3'd5,
    REG_REMAP_TO_MIN      = 3'd6,
    REG_VOLTAGE_OFFSET    = 3'd7
  } cfg_reg_e;

  localparam logic [LIMIT_W-1:0] LOW_CHARGE_LIMIT_RST  = 7'd4;
  localparam logic [MV_W-1:0]    LOW_VOLTAGE_LIMIT_RST = 16'd3100;
  localparam logic [PCT_W-1:0]   REMAP_FROM_MAX_RST    = 8'd100;
  localparam logic [PCT_W-1:0]   REMAP_FROM_MIN_RST    = 8'd0;
  localparam logic [PCT_W-1:0]   REMAP_TO_MAX_RST      = 8'd100;
  localparam logic [PCT_W-1:0]   REMAP_TO_MIN_RST      = 8'd0;
  localparam logic [OFS_W-1:0]   VOLTAGE_OFFSET_RST    = 13'd0;

  typedef struct packed {
    logic [LIMIT_W-1:0] low_charge_limit;
    logic [MV_W-1:0]    low_voltage_limit_mv;
    logic               remap_enable;
    logic [PCT_W-1:0]   remap_from_max;
    logic [PCT_W-1:0]   remap_from_min;
    logic [PCT_W-1:0]   remap_to_max;
    logic [PCT_W-1:0]   remap_to_min;
    logic [OFS_W-1:0]   voltage_offset_mv;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic tab_wr;
    logic cap;
    logic sum;
    logic smooth_ld;
    logic scan_start;
    logic scan_en;
    logic eval;
    logic mul;
    logic div_go_remap;
    logic remap_ld;
    logic out_ld;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic scan_done;
    logic need_div;
  } dp_status_t;

endpackage

// File: sv/bce_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on bce_pkg for operand widths.

module bce_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [bce_pkg::SUM_W-1:0]      dividend_i,
  input  logic [bce_pkg::DVSR_W-1:0]     divisor_i,
  output logic                           done_o,
  output logic [bce_pkg::SUM_W-1:0]      quotient_o
);

  localparam int unsigned CNT_W = $clog2(bce_pkg::SUM_W + 1);

  logic                          busy_q;
  logic                          done_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [bce_pkg::SUM_W-1:0]     quo_q;
  logic [bce_pkg::DVSR_W-1:0]    rem_q;
  logic [bce_pkg::DVSR_W-1:0]    dvsr_q;
  logic [bce_pkg::DVSR_W:0]      shift;
  logic [bce_pkg::DVSR_W:0]      diff;
  logic                          fits;

  assign shift = {rem_q, quo_q[bce_pkg::SUM_W-1]};
  assign diff  = shift - {1'b0, dvsr_q};
  assign fits  = shift >= {1'b0, dvsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(bce_pkg::SUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q  <= dividend_i;
      rem_q  <= '0;
      dvsr_q <= divisor_i;
    end else if (busy_q) begin
      // shift in one quotient bit, keep the partial remainder below the divisor
      quo_q <= {quo_q[bce_pkg::SUM_W-2:0], fits};
      rem_q <= fits ? diff[bce_pkg::DVSR_W-1:0] : shift[bce_pkg::DVSR_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q)
    else $error("divider not busy after start");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(busy_q) && !busy_q))
    else $error("divider done without a running division");

endmodule

// File: sv/bce_ctrl.sv
// Sequencing state machine of the battery charge estimator.
// Depends on bce_pkg for the command and status structs.

module bce_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_op_i,
  output logic                 in_ready_o,
  input  logic                 out_free_i,
  input  bce_pkg::dp_status_t  st_i,
  output bce_pkg::dp_cmd_t     cmd_o
);

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b0_0000_0001,
    ST_SUM     = 9'b0_0000_0010,
    ST_SMOOTH  = 9'b0_0000_0100,
    ST_SCAN    = 9'b0_0000_1000,
    ST_EVAL    = 9'b0_0001_0000,
    ST_RMUL    = 9'b0_0010_0000,
    ST_RDIV_ST = 9'b0_0100_0000,
    ST_RDIV_W  = 9'b0_1000_0000,
    ST_DONE    = 9'b1_0000_0000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (bce_pkg::op_e'(in_op_i) == bce_pkg::OP_TABLE_WR) begin
            cmd_o.tab_wr = 1'b1;
          end else begin
            cmd_o.cap = 1'b1;
            state_d   = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_SMOOTH;
      end
      ST_SMOOTH: begin
        cmd_o.smooth_ld  = 1'b1;
        cmd_o.scan_start = 1'b1;
        state_d          = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (st_i.scan_done) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = st_i.need_div ? ST_RMUL : ST_DONE;
      end
      ST_RMUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_RDIV_ST;
      end
      ST_RDIV_ST: begin
        cmd_o.div_go_remap = 1'b1;
        state_d            = ST_RDIV_W;
      end
      ST_RDIV_W: begin
        if (st_i.div_done) begin
          cmd_o.remap_ld = 1'b1;
          state_d        = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold the result until the output register is free
        if (out_free_i) begin
          cmd_o.out_ld = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_tab_wr_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.tab_wr |=> (state_q == ST_IDLE))
    else $error("table write left the idle state");

  a_out_ld_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_ld |-> out_free_i)
    else $error("result loaded over an untaken result");

endmodule

// File: sv/bce_datapath.sv
// Datapath: sample history, threshold memory, table scan, alarm, remap, offset.
// Depends on bce_pkg and instantiates bce_div.

module bce_datapath #(
  parameter int unsigned PERCENT_STEPS = bce_pkg::PERCENT_STEPS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bce_pkg::dp_cmd_t              cmd_i,
  output bce_pkg::dp_status_t           st_o,
  input  bce_pkg::cfg_t                 cfg_i,
  input  logic [bce_pkg::IDX_W-1:0]     idx_i,
  input  logic [bce_pkg::MV_W-1:0]      mv_i,
  output logic                          res_valid_o,
  output logic [bce_pkg::PCT_W-1:0]     res_pct_o,
  output logic [bce_pkg::ALARM_W-1:0]   res_alarm_o,
  output logic [bce_pkg::MV_W-1:0]      res_mv_o
);

  localparam int unsigned DEPTH = PERCENT_STEPS + 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(PERCENT_STEPS);
  localparam logic [bce_pkg::PCT_W-1:0] TOP_PCT = bce_pkg::PCT_W'(PERCENT_STEPS);
  localparam int unsigned MV_W  = bce_pkg::MV_W;
  localparam int unsigned PCT_W = bce_pkg::PCT_W;
  localparam int unsigned PROD_W = 2 * bce_pkg::SUM_W;

  // ---------------------------------------------------------------- history
  logic [MV_W-1:0]           mv_q;
  logic [MV_W-1:0]           hist_q [bce_pkg::HIST_DEPTH];
  logic                      primed_q;
  logic [bce_pkg::SUM_W-1:0] sum_c;
  logic [bce_pkg::SUM_W-1:0] sum_q;
  logic [PROD_W-1:0]         smooth_prod;
  logic [MV_W-1:0]           smooth_c;
  logic [MV_W-1:0]           smooth_q;

  logic                      div_start;
  logic [bce_pkg::SUM_W-1:0] div_dividend;
  logic [bce_pkg::DVSR_W-1:0] div_divisor;
  logic                      div_done;
  logic [bce_pkg::SUM_W-1:0] div_quo;

  always_comb begin
    sum_c = bce_pkg::SUM_W'(mv_q);
    for (int k = 0; k < bce_pkg::HIST_DEPTH; k++) begin
      sum_c = sum_c + bce_pkg::SUM_W'(hist_q[k]);
    end
  end

  // divide the sum by five: multiply by the scaled reciprocal, keep the integer part
  assign smooth_prod = PROD_W'(sum_q) * PROD_W'(bce_pkg::SMOOTH_RECIP);
  assign smooth_c    = smooth_prod[bce_pkg::SMOOTH_SHIFT +: MV_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q <= 1'b0;
    end else if (cmd_i.cap) begin
      primed_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      mv_q <= mv_i;
      // the first sample fills the whole history
      if (!primed_q) begin
        for (int k = 0; k < bce_pkg::HIST_DEPTH; k++) begin
          hist_q[k] <= mv_i;
        end
      end
    end else if (cmd_i.smooth_ld) begin
      for (int k = 0; k < bce_pkg::HIST_DEPTH - 1; k++) begin
        hist_q[k] <= hist_q[k+1];
      end
      hist_q[bce_pkg::HIST_DEPTH-1] <= smooth_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      sum_q <= sum_c;
    end
    if (cmd_i.smooth_ld) begin
      smooth_q <= smooth_c;
    end
  end

  // ---------------------------------------------------------- remap divider
  logic [PCT_W-1:0] span_in;
  logic [PCT_W-1:0] prod_a;
  logic [PCT_W-1:0] prod_b;
  logic [2*PCT_W-1:0] prod_q;
  logic             neg_q;
  logic             span_neg;

  assign span_in      = cfg_i.remap_from_max - cfg_i.remap_from_min;
  assign div_start    = cmd_i.div_go_remap;
  assign div_dividend = bce_pkg::SUM_W'(prod_q);
  assign div_divisor  = span_in;

  bce_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // -------------------------------------------------------- threshold memory
  logic [MV_W-1:0] thr_mem_q [DEPTH];
  logic [MV_W-1:0] rdata_q;
  logic [AW-1:0]   rd_addr_q;
  logic [AW-1:0]   rd_idx_q;
  logic            issue_done_q;
  logic            rd_pend_q;
  logic            issue;
  logic            tab_in_range;
  logic [AW-1:0]   wr_addr;

  assign tab_in_range = ({1'b0, idx_i} <= TOP_PCT);
  assign wr_addr      = AW'(idx_i);
  assign issue        = cmd_i.scan_en & ~issue_done_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.tab_wr && tab_in_range) begin
      thr_mem_q[wr_addr] <= mv_i;
    end
    if (issue) begin
      rdata_q  <= thr_mem_q[rd_addr_q];
      rd_idx_q <= rd_addr_q;
    end
  end

  // ------------------------------------------------------------- table scan
  logic          ge;
  logic          lt0_q;
  logic          ge_top_q;
  logic          found_q;
  logic          prev_ge_q;
  logic [AW-1:0] found_idx_q;

  assign ge = (smooth_q >= rdata_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_addr_q    <= '0;
      issue_done_q <= 1'b0;
      rd_pend_q    <= 1'b0;
      lt0_q        <= 1'b0;
      ge_top_q     <= 1'b0;
      found_q      <= 1'b0;
      prev_ge_q    <= 1'b0;
      found_idx_q  <= '0;
    end else if (cmd_i.scan_start) begin
      rd_addr_q    <= '0;
      issue_done_q <= 1'b0;
      rd_pend_q    <= 1'b0;
      lt0_q        <= 1'b0;
      ge_top_q     <= 1'b0;
      found_q      <= 1'b0;
      prev_ge_q    <= 1'b0;
    end else begin
      rd_pend_q <= issue;
      if (issue) begin
        if (rd_addr_q == LAST_ADDR) begin
          issue_done_q <= 1'b1;
        end else begin
          rd_addr_q <= rd_addr_q + 1'b1;
        end
      end
      if (rd_pend_q) begin
        prev_ge_q <= ge;
        if (rd_idx_q == '0) begin
          lt0_q <= ~ge;
        end else if (prev_ge_q && !ge && !found_q) begin
          // first bracket entry[i] <= value < entry[i+1]
          found_q     <= 1'b1;
          found_idx_q <= rd_idx_q - 1'b1;
        end
        if (rd_idx_q == LAST_ADDR) begin
          ge_top_q <= ge;
        end
      end
    end
  end

  // ---------------------------------------------------- percent and remap
  logic                        base_valid;
  logic [PCT_W-1:0]            base_pct;
  bce_pkg::alarm_e             alarm_c;
  logic                        below;
  logic                        above;
  logic                        flat;
  logic [PCT_W-1:0]            direct_pct;
  logic                        need_div;
  logic signed [MV_W+1:0]      rep_s;
  logic [MV_W-1:0]             rep_c;

  logic                        res_valid_q;
  logic [PCT_W-1:0]            res_pct_q;
  bce_pkg::alarm_e             res_alarm_q;
  logic [MV_W-1:0]             rep_q;

  assign base_valid = lt0_q | ge_top_q | found_q;

  always_comb begin
    priority if (lt0_q) begin
      base_pct = '0;
    end else if (ge_top_q) begin
      base_pct = TOP_PCT;
    end else if (found_q) begin
      base_pct = PCT_W'(found_idx_q);
    end else begin
      base_pct = '0;
    end
  end

  always_comb begin
    priority if (!base_valid) begin
      alarm_c = bce_pkg::ALARM_NONE;
    end else if (base_pct <= {1'b0, cfg_i.low_charge_limit}) begin
      alarm_c = bce_pkg::ALARM_LOW_CHARGE;
    end else if (mv_q <= cfg_i.low_voltage_limit_mv) begin
      alarm_c = bce_pkg::ALARM_LOW_VOLTAGE;
    end else begin
      alarm_c = bce_pkg::ALARM_NONE;
    end
  end

  assign below      = base_pct < cfg_i.remap_from_min;
  assign above      = base_pct > cfg_i.remap_from_max;
  assign flat       = cfg_i.remap_from_max == cfg_i.remap_from_min;
  // with swapped bounds a percent can be both below and above: below wins
  assign direct_pct = (above & ~below) ? cfg_i.remap_to_max : cfg_i.remap_to_min;
  assign need_div   = cfg_i.remap_enable & base_valid & ~below & ~above & ~flat;

  // raw sample plus signed offset, clamped to the millivolt range
  assign rep_s = $signed({2'b00, mv_q}) + (MV_W+2)'($signed(cfg_i.voltage_offset_mv));

  always_comb begin
    priority if (rep_s[MV_W+1]) begin
      rep_c = '0;
    end else if (rep_s[MV_W]) begin
      rep_c = '1;
    end else begin
      rep_c = rep_s[MV_W-1:0];
    end
  end

  assign span_neg = cfg_i.remap_to_max < cfg_i.remap_to_min;
  assign prod_a   = res_pct_q - cfg_i.remap_from_min;
  assign prod_b   = span_neg ? (cfg_i.remap_to_min - cfg_i.remap_to_max)
                             : (cfg_i.remap_to_max - cfg_i.remap_to_min);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= prod_a * prod_b;
      neg_q  <= span_neg;
    end
    if (cmd_i.eval) begin
      rep_q <= rep_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      res_pct_q   <= '0;
      res_alarm_q <= bce_pkg::ALARM_NONE;
    end else if (cmd_i.eval) begin
      res_valid_q <= base_valid;
      res_alarm_q <= alarm_c;
      // keep the plain percent when a division still has to follow
      if (cfg_i.remap_enable && base_valid && !need_div) begin
        res_pct_q <= direct_pct;
      end else begin
        res_pct_q <= base_pct;
      end
    end else if (cmd_i.remap_ld) begin
      // quotient magnitude truncates toward zero, sign follows the target span
      res_pct_q <= neg_q ? (cfg_i.remap_to_min - div_quo[PCT_W-1:0])
                         : (cfg_i.remap_to_min + div_quo[PCT_W-1:0]);
    end
  end

  assign st_o.div_done  = div_done;
  assign st_o.scan_done = rd_pend_q & (rd_idx_q == LAST_ADDR);
  assign st_o.need_div  = need_div;

  assign res_valid_o = res_valid_q;
  assign res_pct_o   = res_pct_q;
  assign res_alarm_o = res_alarm_q;
  assign res_mv_o    = rep_q;

  a_invalid_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_q |-> (res_pct_q == '0 && res_alarm_q == bce_pkg::ALARM_NONE))
    else $error("failed search left a nonzero percent or alarm");

  a_scan_done_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_o.scan_done |-> $past(cmd_i.scan_en))
    else $error("scan finished without a running scan");

endmodule

// File: sv/battery_charge_estimator.sv
// Battery charge estimator: millivolt samples to charge percent with alarm.
// Input and output use valid/ready. An item with operation 1 writes one threshold
// entry, if its index is at most PERCENT_STEPS, in its accept cycle and gives no
// result; operation 0 is a voltage sample and gives exactly one result.
// A sample is summed with four stored smoothed values and divided by five with a
// reciprocal multiply, then the threshold memory is walked one entry per cycle
// through its registered read port. The percent remap, when it needs a division,
// adds a multiply state, a divider start state and a pass of the bit-serial
// divider. One sample is in work at a time; in_ready_o is high only while no
// sample is in work.
// The result sits in an output register; a new input is taken while it waits,
// and a finished sample holds in the datapath while the receiver stalls.
// Reset clears control state and loads the register defaults; the threshold
// memory is not cleared and must be written before samples are sent.
// The user writes configuration registers through cfg_we_i in idle cycles only;
// this is not enforced. Depends on bce_pkg, bce_ctrl, bce_datapath and bce_div.

module battery_charge_estimator #(
  parameter int unsigned PERCENT_STEPS = bce_pkg::PERCENT_STEPS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              operation_i,
  input  logic [bce_pkg::IDX_W-1:0]         table_index_i,
  input  logic [bce_pkg::MV_W-1:0]          millivolts_i,

  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              valid_res_o,
  output logic [bce_pkg::PCT_W-1:0]         percent_o,
  output logic [bce_pkg::ALARM_W-1:0]       alarm_o,
  output logic [bce_pkg::MV_W-1:0]          reported_mv_o,

  input  logic                              cfg_we_i,
  input  logic [bce_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bce_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  bce_pkg::cfg_t       cfg_q;
  bce_pkg::dp_cmd_t    cmd;
  bce_pkg::dp_status_t st;

  logic                            out_valid_q;
  logic                            out_free;
  logic                            dp_valid;
  logic [bce_pkg::PCT_W-1:0]       dp_pct;
  logic [bce_pkg::ALARM_W-1:0]     dp_alarm;
  logic [bce_pkg::MV_W-1:0]        dp_mv;
  logic                            valid_res_q;
  logic [bce_pkg::PCT_W-1:0]       percent_q;
  logic [bce_pkg::ALARM_W-1:0]     alarm_q;
  logic [bce_pkg::MV_W-1:0]        reported_mv_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_charge_limit     <= bce_pkg::LOW_CHARGE_LIMIT_RST;
      cfg_q.low_voltage_limit_mv <= bce_pkg::LOW_VOLTAGE_LIMIT_RST;
      cfg_q.remap_enable         <= 1'b0;
      cfg_q.remap_from_max       <= bce_pkg::REMAP_FROM_MAX_RST;
      cfg_q.remap_from_min       <= bce_pkg::REMAP_FROM_MIN_RST;
      cfg_q.remap_to_max         <= bce_pkg::REMAP_TO_MAX_RST;
      cfg_q.remap_to_min         <= bce_pkg::REMAP_TO_MIN_RST;
      cfg_q.voltage_offset_mv    <= bce_pkg::VOLTAGE_OFFSET_RST;
    end else if (cfg_we_i) begin
      unique case (bce_pkg::cfg_reg_e'(cfg_index_i))
        bce_pkg::REG_LOW_CHARGE_LIMIT:
          cfg_q.low_charge_limit <= cfg_wdata_i[bce_pkg::LIMIT_W-1:0];
        bce_pkg::REG_LOW_VOLTAGE_LIMIT:
          cfg_q.low_voltage_limit_mv <= cfg_wdata_i[bce_pkg::MV_W-1:0];
        bce_pkg::REG_REMAP_ENABLE:
          cfg_q.remap_enable <= cfg_wdata_i[0];
        bce_pkg::REG_REMAP_FROM_MAX:
          cfg_q.remap_from_max <= cfg_wdata_i[bce_pkg::PCT_W-1:0];
        bce_pkg::REG_REMAP_FROM_MIN:
          cfg_q.remap_from_min <= cfg_wdata_i[bce_pkg::PCT_W-1:0];
        bce_pkg::REG_REMAP_TO_MAX:
          cfg_q.remap_to_max <= cfg_wdata_i[bce_pkg::PCT_W-1:0];
        bce_pkg::REG_REMAP_TO_MIN:
          cfg_q.remap_to_min <= cfg_wdata_i[bce_pkg::PCT_W-1:0];
        bce_pkg::REG_VOLTAGE_OFFSET:
          cfg_q.voltage_offset_mv <= cfg_wdata_i[bce_pkg::OFS_W-1:0];
      endcase
    end
  end

  assign out_free = ~out_valid_q | out_ready_i;

  bce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (operation_i),
    .in_ready_o (in_ready_o),
    .out_free_i (out_free),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  bce_datapath #(
    .PERCENT_STEPS (PERCENT_STEPS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .cfg_i       (cfg_q),
    .idx_i       (table_index_i),
    .mv_i        (millivolts_i),
    .res_valid_o (dp_valid),
    .res_pct_o   (dp_pct),
    .res_alarm_o (dp_alarm),
    .res_mv_o    (dp_mv)
  );

  // output register: set on load, drop after the transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_ld) begin
      valid_res_q   <= dp_valid;
      percent_q     <= dp_pct;
      alarm_q       <= dp_alarm;
      reported_mv_q <= dp_mv;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign valid_res_o   = valid_res_q;
  assign percent_o     = percent_q;
  assign alarm_o       = alarm_q;
  assign reported_mv_o = reported_mv_q;

endmodule
